[hw/rtl/pms_pkg.sv]
package pms_pkg;

    localparam int NUM_STACKS      = 4;
    localparam int MAX_STACK_DEPTH = 256;
    localparam int STORE_DEPTH     = 1024;
    localparam int NUM_SIZE_REGS   = 4;

    localparam int DATA_W   = 32;
    localparam int CNT_W    = 9;
    localparam int IDX_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int SUM_W    = $clog2(NUM_STACKS * MAX_STACK_DEPTH + MAX_STACK_DEPTH);

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(256);

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // one access of the entry store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

    // clamp a size register to the usable capacity range
    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] c;
        c = size;
        if (size == '0) begin
            c = CNT_W'(1);
        end else if (size > CNT_W'(MAX_STACK_DEPTH)) begin
            c = CNT_W'(MAX_STACK_DEPTH);
        end
        return c;
    endfunction

endpackage

[hw/rtl/partitioned_multi_stack_top.sv]
// Channel  | Dir | Fields (low bit first)
// s_axis   | in  | tuser: action[0], stack_index[2:1]; tdata: value[31:0]
// m_axis   | out | tdata: done_res[0], depth_after[9:1], top_value[41:10], is_empty[42]
// cfg      | in  | i_cfg_idx selects size_stack_zero..three, i_cfg_data[8:0]
//
// Each beat passes through capture (ST_IDLE), one store access (ST_EXEC) and the store read (ST_RESP).
// The single-port entry store and its registered read set these steps.
// Reset (synchronous, active low) empties all stacks and sets every size to 256.
// A finished result waits in the output register; a new beat is taken meanwhile and
// holds in its last cycle until the output register frees up.
module partitioned_multi_stack_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pms_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pms_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // value[31:0]
    input  logic [pms_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // action[0], stack_index[2:1]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // done_res, depth_after, top_value, is_empty
);
    import pms_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_size [NUM_SIZE_REGS];
    logic [CNT_W-1:0]  r_fill [NUM_STACKS];

    t_action           r_act;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_val;

    logic              r_done;
    logic [CNT_W-1:0]  r_depth;
    logic              r_use_val;
    logic [ADDR_W-1:0] r_addr;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic             accept;
    logic             do_exec;
    logic             do_resp;

    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] cap;
    logic             push_ok;
    logic             pop_ok;
    logic [CNT_W-1:0] new_fill;
    logic [CNT_W-1:0] pos;
    logic [ADDR_W-1:0] addr;
    t_mem_req         mem_req;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] top;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SIZE_REGS; k++) begin
                r_size[k] <= SIZE_RESET;
            end
        end else if (i_cfg_we) begin
            r_size[i_cfg_idx] <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_RESP;
            ST_RESP: if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        do_exec       = 1'b0;
        do_resp       = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EXEC: do_exec = 1'b1;
            ST_RESP: do_resp = !r_out_valid || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= t_action'(s_axis_tuser[0]);
            r_idx <= s_axis_tuser[2:1];
            r_val <= s_axis_tdata[DATA_W-1:0];
        end
    end

    // decide the operation against the fill count
    assign fill     = r_fill[r_idx];
    assign push_ok  = (r_act == ACT_PUSH) && (fill < cap);
    assign pop_ok   = (r_act == ACT_POP) && (fill != '0);
    always_comb begin
        new_fill = fill;
        if (push_ok) begin
            new_fill = fill + CNT_W'(1);
        end else if (pop_ok) begin
            new_fill = fill - CNT_W'(1);
        end
    end
    // write slot for a push, else the slot of the new top
    assign pos = push_ok ? fill : (new_fill - CNT_W'(1));

    pms_addr u_addr (
        .i_size (r_size),
        .i_idx  (r_idx),
        .i_pos  (pos),
        .o_cap  (cap),
        .o_addr (addr)
    );

    // hold the read address of the operation while its result waits
    always_ff @(posedge i_clk) begin
        if (do_exec) begin
            r_addr <= addr;
        end
    end

    assign mem_req.addr  = do_exec ? addr : r_addr;
    assign mem_req.we    = do_exec && push_ok;
    assign mem_req.wdata = r_val;

    pms_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // update fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_fill[k] <= '0;
            end
        end else if (do_exec) begin
            r_fill[r_idx] <= new_fill;
        end
    end

    // hold the outcome while the store read completes
    always_ff @(posedge i_clk) begin
        if (do_exec) begin
            r_done    <= push_ok || pop_ok;
            r_depth   <= new_fill;
            r_use_val <= push_ok;
        end
    end

    // an empty stack reports zero; a fresh push is its own top; otherwise take the read data
    always_comb begin
        if (r_depth == '0) begin
            top = '0;
        end else if (r_use_val) begin
            top = r_val;
        end else begin
            top = rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_resp) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_resp) begin
            r_out_data <= {5'b0, (r_depth == '0), top, r_depth, r_done};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[hw/rtl/pms_store.sv]
module pms_store (
    input  logic                     i_clk,
    input  pms_pkg::t_mem_req        i_req,
    output logic [pms_pkg::DATA_W-1:0] o_rdata
);
    import pms_pkg::*;

    logic [DATA_W-1:0] r_mem [STORE_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write on request, read the same address every cycle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pms_addr.sv]
module pms_addr (
    input  logic [pms_pkg::CNT_W-1:0]  i_size [pms_pkg::NUM_SIZE_REGS],
    input  logic [pms_pkg::IDX_W-1:0]  i_idx,
    input  logic [pms_pkg::CNT_W-1:0]  i_pos,
    output logic [pms_pkg::CNT_W-1:0]  o_cap,
    output logic [pms_pkg::ADDR_W-1:0] o_addr
);
    import pms_pkg::*;

    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] full_addr;

    // sum the capacities of the stacks below the addressed one
    always_comb begin
        base = '0;
        for (int k = 0; k < NUM_STACKS; k++) begin
            if (k < int'(i_idx)) begin
                base = base + SUM_W'(clamp_cap(i_size[k]));
            end
        end
    end

    assign o_cap     = clamp_cap(i_size[i_idx]);
    assign full_addr = base + SUM_W'(i_pos);
    // wrap modulo the store depth
    assign o_addr    = full_addr[ADDR_W-1:0];

endmodule
